>>> src/lplrc_pkg.sv
// shared types and constants of the low-power-listening retransmit controller
`default_nettype none
package lplrc_pkg;

  localparam int unsigned DATA_W = 16;
  localparam int unsigned CNT_W  = 18;

  typedef logic [1:0]        kind_t;
  typedef logic [1:0]        mode_t;
  typedef logic [1:0]        code_t;
  typedef logic [1:0]        cfg_index_t;
  typedef logic [DATA_W-1:0] cfg_data_t;
  typedef logic [CNT_W-1:0]  count_t;

  // request kinds
  localparam kind_t KIND_TX_REQ    = 2'd0;
  localparam kind_t KIND_SEND_DONE = 2'd1;
  localparam kind_t KIND_TICK      = 2'd2;

  // transmit modes
  localparam mode_t MODE_IDLE    = 2'd0;
  localparam mode_t MODE_SENDING = 2'd1;
  localparam mode_t MODE_EXPIRED = 2'd2;

  // result actions
  localparam logic ACT_SEND   = 1'b0;
  localparam logic ACT_REPORT = 1'b1;

  // report codes
  localparam code_t CODE_SUCCESS = 2'd0;
  localparam code_t CODE_BUSY    = 2'd1;
  localparam code_t CODE_FAILED  = 2'd2;

  // configuration register indexes
  localparam cfg_index_t CFG_LPL_ON          = 2'd0;
  localparam cfg_index_t CFG_LISTEN_WINDOW   = 2'd1;
  localparam cfg_index_t CFG_WAKEUP_INTERVAL = 2'd2;

  typedef struct packed {
    kind_t kind;
    logic  needs_ack;
    logic  send_ok;
  } item_t;

  typedef struct packed {
    logic  action;
    code_t done_code;
  } result_t;

  typedef struct packed {
    logic      lpl_on;
    cfg_data_t listen_window_us;
    cfg_data_t wakeup_interval_us;
  } cfg_t;

  // handshake between the step logic and the stages around it
  typedef struct packed {
    logic take;
    logic load;
  } step_ctl_t;

endpackage
`default_nettype wire

>>> src/lplrc_stream_if.sv
// request and result channel interfaces
`default_nettype none
interface lplrc_req_if;
  logic          valid;
  logic          ready;
  lplrc_pkg::kind_t kind;
  logic          needs_ack;
  logic          send_ok;

  modport source (output valid, output kind, output needs_ack, output send_ok, input ready);
  modport sink   (input valid, input kind, input needs_ack, input send_ok, output ready);
endinterface

interface lplrc_res_if;
  logic             valid;
  logic             ready;
  logic             action;
  lplrc_pkg::code_t done_code;

  modport source (output valid, output action, output done_code, input ready);
  modport sink   (input valid, input action, input done_code, output ready);
endinterface
`default_nettype wire

>>> src/lplrc_in_stage.sv
// input register holding one accepted request
`default_nettype none
module lplrc_in_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire lplrc_pkg::item_t in_item,
  input  wire logic             take,
  output logic                  held_valid,
  output lplrc_pkg::item_t      held_item
);

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule
`default_nettype wire

>>> src/lplrc_step.sv
// mode, ack flag and window countdown with their per-request update
`default_nettype none
module lplrc_step (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire lplrc_pkg::cfg_t    cfg,
  input  wire logic               held_valid,
  input  wire lplrc_pkg::item_t   held_item,
  input  wire logic               out_free,
  output lplrc_pkg::step_ctl_t    ctl,
  output lplrc_pkg::result_t      result
);

  lplrc_pkg::mode_t  lpl_mode, lpl_mode_next;
  logic              stored_needs_ack, stored_needs_ack_next;
  lplrc_pkg::count_t window_countdown, window_countdown_next;
  lplrc_pkg::count_t load_value;
  logic              emit;

  assign load_value = lplrc_pkg::CNT_W'({2'b00, cfg.wakeup_interval_us})
                    + lplrc_pkg::CNT_W'({1'b0, cfg.listen_window_us, 1'b0});

  always_comb begin
    lpl_mode_next         = lpl_mode;
    stored_needs_ack_next = stored_needs_ack;
    window_countdown_next = window_countdown;
    emit                  = 1'b0;
    result.action         = lplrc_pkg::ACT_SEND;
    result.done_code      = lplrc_pkg::CODE_SUCCESS;
    case (held_item.kind)
      lplrc_pkg::KIND_TX_REQ: begin
        emit = 1'b1;
        if (cfg.lpl_on) begin
          if (lpl_mode == lplrc_pkg::MODE_IDLE) begin
            lpl_mode_next         = lplrc_pkg::MODE_SENDING;
            stored_needs_ack_next = held_item.needs_ack;
            window_countdown_next = load_value;
          end else begin
            result.action    = lplrc_pkg::ACT_REPORT;
            result.done_code = lplrc_pkg::CODE_BUSY;
          end
        end
      end
      lplrc_pkg::KIND_SEND_DONE: begin
        if (!cfg.lpl_on) begin
          emit             = 1'b1;
          result.action    = lplrc_pkg::ACT_REPORT;
          result.done_code = held_item.send_ok ? lplrc_pkg::CODE_SUCCESS
                                               : lplrc_pkg::CODE_FAILED;
        end else if (lpl_mode != lplrc_pkg::MODE_IDLE) begin
          emit = 1'b1;
          if (stored_needs_ack && held_item.send_ok) begin
            lpl_mode_next         = lplrc_pkg::MODE_IDLE;
            window_countdown_next = '0;
            result.action         = lplrc_pkg::ACT_REPORT;
          end else if (lpl_mode == lplrc_pkg::MODE_EXPIRED) begin
            // window over: ack packets fail, plain packets succeed
            lpl_mode_next    = lplrc_pkg::MODE_IDLE;
            result.action    = lplrc_pkg::ACT_REPORT;
            result.done_code = stored_needs_ack ? lplrc_pkg::CODE_FAILED
                                                : lplrc_pkg::CODE_SUCCESS;
          end
        end
      end
      lplrc_pkg::KIND_TICK: begin
        if (lpl_mode == lplrc_pkg::MODE_SENDING) begin
          if (window_countdown <= lplrc_pkg::count_t'(1)) begin
            window_countdown_next = '0;
            lpl_mode_next         = lplrc_pkg::MODE_EXPIRED;
          end else begin
            window_countdown_next = window_countdown - lplrc_pkg::count_t'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign ctl.take = held_valid && (!emit || out_free);
  assign ctl.load = held_valid && emit && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      lpl_mode         <= lplrc_pkg::MODE_IDLE;
      stored_needs_ack <= 1'b0;
      window_countdown <= '0;
    end else if (ctl.take) begin
      lpl_mode         <= lpl_mode_next;
      stored_needs_ack <= stored_needs_ack_next;
      window_countdown <= window_countdown_next;
    end
  end

endmodule
`default_nettype wire

>>> src/lplrc_out_stage.sv
// result register in front of the result channel
`default_nettype none
module lplrc_out_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire lplrc_pkg::result_t result,
  output logic                    out_free,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output lplrc_pkg::result_t      out_result
);

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_result <= result;
    end
  end

endmodule
`default_nettype wire

>>> src/lpl_retransmit_controller_core.sv
// top level of the low-power-listening retransmit controller
// flow: a request is taken into the input register and handled there by the step logic;
//   its result goes into the result register that drives the result channel
// throughput: one request per cycle; only a stalled result channel holds requests back
// reset: synchronous active-high rst clears the mode to idle, the ack flag, the
//   countdown, all configuration registers and both stage valid flags
`default_nettype none
module lpl_retransmit_controller_core (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration write port
  input  wire logic                  cfg_we,
  input  wire lplrc_pkg::cfg_index_t cfg_index,
  input  wire lplrc_pkg::cfg_data_t  cfg_data,
  // request channel: transmit requests, send completions and microsecond ticks
  lplrc_req_if.sink                  req,
  // result channel: send orders and done reports
  lplrc_res_if.source                res
);

  lplrc_pkg::cfg_t      cfg;
  lplrc_pkg::item_t     req_item;
  lplrc_pkg::item_t     held_item;
  logic                 held_valid;
  lplrc_pkg::step_ctl_t ctl;
  lplrc_pkg::result_t   step_result;
  lplrc_pkg::result_t   out_result;
  logic                 out_free;

  // configuration registers; writes to an unused index are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lplrc_pkg::CFG_LPL_ON:          cfg.lpl_on             <= cfg_data[0];
        lplrc_pkg::CFG_LISTEN_WINDOW:   cfg.listen_window_us   <= cfg_data;
        lplrc_pkg::CFG_WAKEUP_INTERVAL: cfg.wakeup_interval_us <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign req_item.kind      = req.kind;
  assign req_item.needs_ack = req.needs_ack;
  assign req_item.send_ok   = req.send_ok;

  // input register: frees up as soon as the held request is handled
  lplrc_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_ready   (req.ready),
    .in_item    (req_item),
    .take       (ctl.take),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  // mode and countdown update; a request without a result never waits on the output
  lplrc_step u_step (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .held_valid (held_valid),
    .held_item  (held_item),
    .out_free   (out_free),
    .ctl        (ctl),
    .result     (step_result)
  );

  // result register decouples the result channel from the request side
  lplrc_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .load       (ctl.load),
    .result     (step_result),
    .out_free   (out_free),
    .out_valid  (res.valid),
    .out_ready  (res.ready),
    .out_result (out_result)
  );

  assign res.action    = out_result.action;
  assign res.done_code = out_result.done_code;

endmodule
`default_nettype wire

>>> src/lplrc_checker.sv
// port-level checks of the retransmit controller and their binding
`default_nettype none
module lplrc_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             req_valid,
  input wire logic             req_ready,
  input wire logic             res_valid,
  input wire logic             res_ready,
  input wire logic             res_action,
  input wire lplrc_pkg::code_t res_done_code
);

  // nothing comes out in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // with an empty result register the request side is never blocked
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> req_ready)
    else $error("request blocked while result register is empty");

  // send orders always carry a zero code
  a_send_code: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_action == lplrc_pkg::ACT_SEND)
      |-> res_done_code == lplrc_pkg::CODE_SUCCESS)
    else $error("send order with nonzero code");

  // stalled result holds its value
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_action)
      && $stable(res_done_code)))
    else $error("stalled result changed");

endmodule

bind lpl_retransmit_controller_core lplrc_checker u_lplrc_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .res_action    (res.action),
  .res_done_code (res.done_code)
);
`default_nettype wire
